/* rtl/cmm_pkg.sv */
// Package: shared types, constants and codes for the confusion matrix metrics unit.
`default_nettype none
package cmm_pkg;
    localparam int DEF_MAX_CLASSES = 32;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int SUM_W = 37;
    localparam int Q_W = 17;
    // Internal sum and divider width: covers the grand total of 63 x 63 cells of 48 bits.
    localparam int ACC_W = 60;
    localparam logic [Q_W-1:0] Q_ONE = 17'd65536;

    // Register byte addresses on the configuration port.
    localparam logic [1:0] ADDR_CLASSES = 2'd0;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  actual_label;
        logic [5:0]  predicted_label;
        logic [31:0] increment;
    } in_item_t;

    typedef struct packed {
        logic [4:0]       class_index;
        logic             is_summary;
        logic             last;
        logic [SUM_W-1:0] correct_count;
        logic [SUM_W-1:0] row_total;
        logic [SUM_W-1:0] col_total;
        logic [Q_W-1:0]   recall_q16;
        logic [Q_W-1:0]   precision_q16;
        logic [Q_W-1:0]   jaccard_q16;
        logic [Q_W-1:0]   accuracy_q16;
        logic [31:0]      dropped_count;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_CLR_SWEEP,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WAIT,
        ST_ACC_WR,
        ST_CLR,
        ST_RPT_INIT,
        ST_RPT_SCAN,
        ST_RPT_DRAIN,
        ST_RPT_DIV_R,
        ST_RPT_DIV_P,
        ST_RPT_DIV_J,
        ST_RPT_EMIT,
        ST_SUM_MR,
        ST_SUM_MP,
        ST_SUM_MJ,
        ST_SUM_ACC,
        ST_SUM_EMIT
    } state_t;

    // Divider request: numerator / denominator; mode selects Q16 ratio or mean.
    typedef struct packed {
        logic             start;
        logic             mean;
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [Q_W-1:0] q;
    } div_rsp_t;
endpackage
`default_nettype wire

/* rtl/cmm_div.sv */
// Shared restoring divider: rounded Q1.16 ratio or rounded mean, one bit a cycle.
`default_nettype none
module cmm_div
    import cmm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  div_req_t      req,
    output div_rsp_t      rsp
);
    logic [ACC_W:0]   rem_reg, rem_next;
    logic [ACC_W-1:0] den_reg, den_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        mean_reg, mean_next;
    logic [Q_W-1:0] q_reg, q_next;
    logic [ACC_W:0]   sh;
    logic [ACC_W-1:0] qtmp;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mean_next = mean_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        sh   = '0;
        qtmp = '0;
        if (req.start)
        begin
            mean_next = req.mean;
            den_next  = req.den;
            if (req.den == '0)
            begin
                q_next = '0;
                done_next = 1'b1;
            end
            else if (!req.mean && req.num >= req.den)
            begin
                q_next = Q_ONE;
                done_next = 1'b1;
            end
            else if (req.mean)
            begin
                // Long division of (sum + den/2) by den, ACC_W steps.
                rem_next = '0;
                quo_next = req.num + {1'b0, req.den[ACC_W-1:1]};
                cnt_next = 7'(ACC_W);
                busy_next = 1'b1;
            end
            else
            begin
                rem_next = {1'b0, req.num};
                quo_next = '0;
                cnt_next = 7'd17;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (mean_reg)
            begin
                sh = {rem_reg[ACC_W-1:0], quo_reg[ACC_W-1]};
                qtmp = {quo_reg[ACC_W-2:0], 1'b0};
                if (sh >= {1'b0, den_reg})
                begin
                    sh = sh - {1'b0, den_reg};
                    qtmp[0] = 1'b1;
                end
            end
            else
            begin
                sh = {rem_reg[ACC_W-1:0], 1'b0};
                qtmp = {quo_reg[ACC_W-2:0], 1'b0};
                if (sh >= {1'b0, den_reg})
                begin
                    sh = sh - {1'b0, den_reg};
                    qtmp[0] = 1'b1;
                end
            end
            rem_next = sh;
            quo_next = qtmp;
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (mean_reg)
                    q_next = qtmp[Q_W-1:0];
                else
                    q_next = Q_W'((qtmp[17:0] + 18'd1) >> 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        mean_reg <= mean_next;
        q_reg    <= q_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(req.start))
        else $error("divider done held");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider started while busy");
    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !mean_reg) |-> q_reg <= Q_ONE)
        else $error("ratio above one");
endmodule
`default_nettype wire

/* rtl/confusion_matrix_metrics_unit.sv */
// Top level: confusion matrix count store, sequencer and metric reporting.
`default_nettype none
// The unit holds a MAX_CLASSES x MAX_CLASSES store of saturating counts in a
// single-port memory addressed by (actual, predicted); each index is padded to
// a power of two, so the memory has 2^(2*clog2(MAX_CLASSES)) cells. Items are
// taken one at a time. An accumulate transaction runs accept, read, wait, and
// saturating add and write back; one with a label out of range is dropped in
// the read step. A clear transaction sweeps the memory one cell a cycle; the
// same sweep runs after reset, during which no item is taken. A report
// transaction scans, for each class, its row and column through the one
// memory port (2*N reads), then runs recall, precision and Jaccard through a
// shared divider, and finally three means and the accuracy ratio for the
// summary. Each result waits in the output register until the receiver
// takes it.
module confusion_matrix_metrics_unit
    import cmm_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data
);
    localparam int IW = $clog2(MAX_CLASSES);
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int ADD_W = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
    localparam logic [COUNT_WIDTH-1:0] CELL_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]          mem_addr;
    logic                   mem_we;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    state_t state_reg, state_next;
    logic [5:0]  classes_reg;
    logic [31:0] drop_reg, drop_next;
    in_item_t    item_reg, item_next;
    logic [AW:0] sweep_reg, sweep_next;
    logic [IW:0] cls_reg, cls_next;
    logic [IW:0] j_reg, j_next;
    logic        phase_reg, phase_next;
    logic        rd_vld_reg, rd_vld_next;
    logic        rd_col_reg, rd_col_next;
    logic [ACC_W-1:0] d_reg, d_next, row_reg, row_next, col_reg, col_next;
    logic [ACC_W-1:0] diag_total_reg, diag_total_next, grand_reg, grand_next;
    logic [23:0] rsum_reg, rsum_next, psum_reg, psum_next, jsum_reg, jsum_next;
    logic [IW:0] rcnt_reg, rcnt_next;
    logic [Q_W-1:0] rc_reg, rc_next, pr_reg, pr_next, jc_reg, jc_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic [IW:0] n_eff;
    logic [ACC_W-1:0] uni;
    logic [ADD_W-1:0] acc_sum;

    cmm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Effective class count: zero reads as one, above range as MAX_CLASSES.
    always_comb
    begin
        if (classes_reg == 6'd0)
            n_eff = (IW+1)'(1);
        else if (32'(classes_reg) > MAX_CLASSES)
            n_eff = (IW+1)'(MAX_CLASSES);
        else
            n_eff = (IW+1)'(classes_reg);
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CLASSES) ? {26'd0, classes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            classes_reg <= 6'd32;
        else if (psel && penable && pwrite && paddr == ADDR_CLASSES)
            classes_reg <= pwdata[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    assign uni = row_reg + col_reg - d_reg;
    assign acc_sum = ADD_W'(rd_data_reg) + ADD_W'(item_reg.increment);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR_SWEEP, ST_CLR:
                if (sweep_reg == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                begin
                    case (in_data.kind)
                        KIND_ACC:    state_next = ST_ACC_RD;
                        KIND_CLEAR:  state_next = ST_CLR;
                        KIND_REPORT: state_next = ST_RPT_INIT;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            ST_ACC_RD:
                state_next = (32'(item_reg.actual_label) < 32'(n_eff) &&
                              32'(item_reg.predicted_label) < 32'(n_eff))
                             ? ST_ACC_WAIT : ST_IDLE;
            ST_ACC_WAIT: state_next = ST_ACC_WR;
            ST_ACC_WR:   state_next = ST_IDLE;
            ST_RPT_INIT: state_next = ST_RPT_SCAN;
            ST_RPT_SCAN:
                if (phase_reg && j_reg == n_eff - 1'b1) state_next = ST_RPT_DRAIN;
            ST_RPT_DRAIN: state_next = ST_RPT_DIV_R;
            ST_RPT_DIV_R: if (drsp.done) state_next = ST_RPT_DIV_P;
            ST_RPT_DIV_P: if (drsp.done) state_next = ST_RPT_DIV_J;
            // Equal intersection and union skips the divider.
            ST_RPT_DIV_J: if (drsp.done || uni == d_reg) state_next = ST_RPT_EMIT;
            ST_RPT_EMIT:
                if (!out_valid_reg)
                    state_next = (cls_reg == n_eff - 1'b1) ? ST_SUM_MR : ST_RPT_INIT;
            ST_SUM_MR:  if (drsp.done) state_next = ST_SUM_MP;
            ST_SUM_MP:  if (drsp.done) state_next = ST_SUM_MJ;
            ST_SUM_MJ:  if (drsp.done) state_next = ST_SUM_ACC;
            ST_SUM_ACC: if (drsp.done) state_next = ST_SUM_EMIT;
            ST_SUM_EMIT: if (!out_valid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        item_next = item_reg;
        drop_next = drop_reg;
        sweep_next = sweep_reg;
        cls_next = cls_reg;
        j_next = j_reg;
        phase_next = phase_reg;
        rd_vld_next = 1'b0;
        rd_col_next = rd_col_reg;
        d_next = d_reg; row_next = row_reg; col_next = col_reg;
        diag_total_next = diag_total_reg; grand_next = grand_reg;
        rsum_next = rsum_reg; psum_next = psum_reg; jsum_next = jsum_reg;
        rcnt_next = rcnt_reg;
        rc_next = rc_reg; pr_next = pr_reg; jc_next = jc_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we = 1'b0;
        mem_wdata = '0;
        mem_addr = {item_reg.actual_label[IW-1:0], item_reg.predicted_label[IW-1:0]};
        dreq = '0;
        in_stall = (state_reg != ST_IDLE);

        case (state_reg)
            ST_CLR_SWEEP, ST_CLR:
            begin
                mem_we = 1'b1;
                mem_addr = sweep_reg[AW-1:0];
                sweep_next = sweep_reg + 1'b1;
            end
            ST_IDLE:
            begin
                sweep_next = '0;
                if (in_valid) item_next = in_data;
                cls_next = '0;
                diag_total_next = '0; grand_next = '0;
                rsum_next = '0; psum_next = '0; jsum_next = '0;
                rcnt_next = '0;
            end
            ST_ACC_RD:
                if (!(32'(item_reg.actual_label) < 32'(n_eff) &&
                      32'(item_reg.predicted_label) < 32'(n_eff)))
                    if (drop_reg != 32'hFFFF_FFFF) drop_next = drop_reg + 32'd1;
            ST_ACC_WR:
            begin
                mem_we = 1'b1;
                mem_wdata = (acc_sum > ADD_W'(CELL_MAX)) ? CELL_MAX
                                                         : acc_sum[COUNT_WIDTH-1:0];
            end
            ST_RPT_INIT:
            begin
                j_next = '0; phase_next = 1'b0;
                d_next = '0; row_next = '0; col_next = '0;
            end
            ST_RPT_SCAN, ST_RPT_DRAIN:
            begin
                // Alternate row cell (cls, j) and column cell (j, cls).
                if (state_reg == ST_RPT_SCAN)
                begin
                    mem_addr = phase_reg ? {j_reg[IW-1:0], cls_reg[IW-1:0]}
                                         : {cls_reg[IW-1:0], j_reg[IW-1:0]};
                    rd_vld_next = 1'b1;
                    rd_col_next = phase_reg;
                    phase_next = !phase_reg;
                    if (phase_reg) j_next = j_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (rd_col_reg)
                        col_next = col_reg + ACC_W'(rd_data_reg);
                    else
                    begin
                        row_next = row_reg + ACC_W'(rd_data_reg);
                        if (j_reg == cls_reg + (phase_reg ? 1'b0 : 1'b1) &&
                            state_reg == ST_RPT_SCAN)
                            d_next = ACC_W'(rd_data_reg);
                        else if (state_reg == ST_RPT_DRAIN && j_reg == cls_reg + 1'b1)
                            d_next = ACC_W'(rd_data_reg);
                    end
                end
                if (state_reg == ST_RPT_DRAIN)
                begin
                    dreq.start = 1'b1;
                    dreq.num = d_next;
                    dreq.den = row_next;
                end
            end
            ST_RPT_DIV_R:
                if (drsp.done)
                begin
                    rc_next = drsp.q;
                    dreq.start = 1'b1;
                    dreq.num = d_reg;
                    dreq.den = col_reg;
                end
            ST_RPT_DIV_P:
                if (drsp.done)
                begin
                    pr_next = drsp.q;
                    dreq.start = (uni != d_reg);
                    dreq.num = d_reg;
                    dreq.den = uni;
                end
            ST_RPT_DIV_J:
                if (drsp.done || uni == d_reg)
                    jc_next = (uni == d_reg) ? Q_ONE : drsp.q;
            ST_RPT_EMIT:
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.class_index = 5'(cls_reg);
                    out_next.correct_count = (d_reg > ACC_W'(SUM_MAX)) ? SUM_MAX
                                             : SUM_W'(d_reg);
                    out_next.row_total = (row_reg > ACC_W'(SUM_MAX)) ? SUM_MAX
                                         : SUM_W'(row_reg);
                    out_next.col_total = (col_reg > ACC_W'(SUM_MAX)) ? SUM_MAX
                                         : SUM_W'(col_reg);
                    out_next.recall_q16 = rc_reg;
                    out_next.precision_q16 = pr_reg;
                    out_next.jaccard_q16 = jc_reg;
                    out_next.dropped_count = drop_reg;
                    if (row_reg != '0)
                    begin
                        rsum_next = rsum_reg + 24'(rc_reg);
                        rcnt_next = rcnt_reg + 1'b1;
                    end
                    psum_next = psum_reg + 24'(pr_reg);
                    jsum_next = jsum_reg + 24'(jc_reg);
                    diag_total_next = diag_total_reg + d_reg;
                    grand_next = grand_reg + row_reg;
                    cls_next = cls_reg + 1'b1;
                    if (cls_reg == n_eff - 1'b1)
                    begin
                        dreq.start = 1'b1;
                        dreq.mean = 1'b1;
                        dreq.num = ACC_W'(rsum_next);
                        dreq.den = ACC_W'(rcnt_next);
                    end
                end
            ST_SUM_MR:
                if (drsp.done)
                begin
                    rc_next = drsp.q;
                    dreq.start = 1'b1; dreq.mean = 1'b1;
                    dreq.num = ACC_W'(psum_reg); dreq.den = ACC_W'(n_eff);
                end
            ST_SUM_MP:
                if (drsp.done)
                begin
                    pr_next = drsp.q;
                    dreq.start = 1'b1; dreq.mean = 1'b1;
                    dreq.num = ACC_W'(jsum_reg); dreq.den = ACC_W'(n_eff);
                end
            ST_SUM_MJ:
                if (drsp.done)
                begin
                    jc_next = drsp.q;
                    dreq.start = 1'b1;
                    dreq.num = diag_total_reg; dreq.den = grand_reg;
                end
            ST_SUM_EMIT:
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.is_summary = 1'b1;
                    out_next.last = 1'b1;
                    out_next.correct_count = (diag_total_reg > ACC_W'(SUM_MAX)) ? SUM_MAX
                                             : SUM_W'(diag_total_reg);
                    out_next.row_total = (grand_reg > ACC_W'(SUM_MAX)) ? SUM_MAX
                                         : SUM_W'(grand_reg);
                    out_next.recall_q16 = rc_reg;
                    out_next.precision_q16 = pr_reg;
                    out_next.jaccard_q16 = jc_reg;
                    out_next.accuracy_q16 = d_reg[Q_W-1:0];
                    out_next.dropped_count = drop_reg;
                end
            default: ;
        endcase
        // Accuracy lands in d_reg once the summary scan is done with it.
        if (state_reg == ST_SUM_ACC && drsp.done)
            d_next = ACC_W'(drsp.q);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR_SWEEP;
            drop_reg <= '0;
            sweep_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            cls_reg <= '0;
            j_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drop_reg <= drop_next;
            sweep_reg <= sweep_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg <= rd_vld_next;
            cls_reg <= cls_next;
            j_reg <= j_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rd_col_reg <= rd_col_next;
        d_reg <= d_next; row_reg <= row_next; col_reg <= col_next;
        diag_total_reg <= diag_total_next; grand_reg <= grand_next;
        rsum_reg <= rsum_next; psum_reg <= psum_next; jsum_reg <= jsum_next;
        rcnt_reg <= rcnt_next;
        rc_reg <= rc_next; pr_reg <= pr_next; jc_reg <= jc_next;
        out_reg <= out_next;
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("item taken while busy");
    a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped");
    a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg >= $past(drop_reg) || !$past(rst_n))
        else $error("drop counter decreased");
endmodule
`default_nettype wire
